>>> rtl/core/mcp_pkg.sv
// ============================================================================
// mcp_pkg
// Shared types for the collinear point search: sequencer states and the
// control word passed from the sequencer to the line test unit.
// ============================================================================
package mcp_pkg;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDA   = 9'b000000010,
        S_RDB   = 9'b000000100,
        S_AB    = 9'b000001000,
        S_PRIME = 9'b000010000,
        S_PH0   = 9'b000100000,
        S_PH1   = 9'b001000000,
        S_PEND  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic load_a;     // capture first point of the pair
        logic load_ab;    // capture pair direction vector
        logic load_k;     // capture offset of the scanned point
        logic mul_first;  // first half of the cross product
    } t_unit_ctl;

endpackage

>>> rtl/core/mcp_line_unit.sv
// ============================================================================
// mcp_line_unit
// Cross-product line test with one shared multiplier used twice per point.
// ============================================================================
module mcp_line_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  mcp_pkg::t_unit_ctl     i_ctl,
    input  logic [COORD_WIDTH-1:0] i_rd_x,
    input  logic [COORD_WIDTH-1:0] i_rd_y,
    output logic                   o_on_line
);
    import mcp_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic [COORD_WIDTH-1:0] r_ax;
    logic [COORD_WIDTH-1:0] r_ay;
    logic signed [DW-1:0]   r_dxab;
    logic signed [DW-1:0]   r_dyab;
    logic                   r_same;
    logic signed [DW-1:0]   r_dx;
    logic signed [DW-1:0]   r_dy;
    logic signed [PW-1:0]   r_prod;

    logic signed [DW-1:0]   dx_rd;
    logic signed [DW-1:0]   dy_rd;
    logic signed [DW-1:0]   mul_a;
    logic signed [DW-1:0]   mul_b;
    logic signed [PW-1:0]   prod;

    // offsets of the point on the read port from the first point of the pair
    assign dx_rd = $signed({i_rd_x[COORD_WIDTH-1], i_rd_x}) - $signed({r_ax[COORD_WIDTH-1], r_ax});
    assign dy_rd = $signed({i_rd_y[COORD_WIDTH-1], i_rd_y}) - $signed({r_ay[COORD_WIDTH-1], r_ay});

    assign mul_a = i_ctl.mul_first ? r_dxab : r_dyab;
    assign mul_b = i_ctl.mul_first ? r_dy   : r_dx;
    assign prod  = mul_a * mul_b;

    // coincident pair: horizontal line through the first point
    assign o_on_line = r_same ? (r_dy == '0) : (prod == r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_a) begin
            r_ax <= i_rd_x;
            r_ay <= i_rd_y;
        end
        if (i_ctl.load_ab) begin
            r_dxab <= dx_rd;
            r_dyab <= dy_rd;
            r_same <= (dx_rd == '0) && (dy_rd == '0);
        end
        if (i_ctl.load_k) begin
            r_dx <= dx_rd;
            r_dy <= dy_rd;
        end
        if (i_ctl.mul_first) begin
            r_prod <= prod;
        end
    end

endmodule

>>> rtl/core/max_collinear_points_unit.sv
// ============================================================================
// max_collinear_points_unit
// Finds the line through the most stored points of a loaded set.
// ============================================================================
// Usage: present a point on i_point_x/i_point_y with start high while busy is
// low; each such cycle is one transaction and stores one point (points past
// MAX_POINTS are discarded and flagged). A point with i_last_point high closes
// the set and starts the search; busy stays high until the result has gone.
// Loading takes one cycle per point. With n points stored the search reads
// every pair (i<j) and scans all n points for it through one shared
// multiplier and one memory read port, then raises the result strobe.
// With fewer than two points the strobe comes the cycle after the last point.
// The result is on the o_ ports for the single cycle that o_result_strobe is
// high; the receiver cannot stall it. The set is then cleared for the next.
// Reset returns the sequencer to idle with an empty set; stored coordinates
// are not cleared, only overwritten.
// ============================================================================
module max_collinear_points_unit #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [COORD_WIDTH-1:0]              i_point_x,
    input  logic [COORD_WIDTH-1:0]              i_point_y,
    input  logic                                i_last_point,
    output logic                                o_result_strobe,
    output logic [$clog2(MAX_POINTS+1)-1:0]     o_best_count,
    output logic [$clog2(MAX_POINTS)-1:0]       o_first_index,
    output logic [$clog2(MAX_POINTS)-1:0]       o_second_index,
    output logic                                o_line_valid,
    output logic                                o_points_dropped
);
    import mcp_pkg::*;

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int MW   = 2 * COORD_WIDTH;

    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_loaded, n_loaded;
    logic              r_ovf, n_ovf;
    logic              r_valid, n_valid;
    logic [IDXW-1:0]   r_a, n_a;
    logic [IDXW-1:0]   r_b, n_b;
    logic [IDXW-1:0]   r_k, n_k;
    logic [CNTW-1:0]   r_run, n_run;
    logic [CNTW-1:0]   r_best, n_best;
    logic [IDXW-1:0]   r_bf, n_bf;
    logic [IDXW-1:0]   r_bs, n_bs;

    logic [MW-1:0]     r_mem [MAX_POINTS];
    logic [MW-1:0]     r_rd;
    logic              mem_we;
    logic [IDXW-1:0]   rd_addr;

    t_unit_ctl         ctl;
    logic              on_line;
    logic [CNTW-1:0]   cnt_after;
    logic [CNTW-1:0]   k_next;
    logic [CNTW-1:0]   b_next;
    logic [CNTW-1:0]   a_plus2;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_loaded[IDXW-1:0]] <= {i_point_x, i_point_y};
        end
        r_rd <= r_mem[rd_addr];
    end

    mcp_line_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_rd_x    (r_rd[MW-1:COORD_WIDTH]),
        .i_rd_y    (r_rd[COORD_WIDTH-1:0]),
        .o_on_line (on_line)
    );

    assign cnt_after = r_loaded + CNTW'(1);
    assign k_next    = CNTW'(r_k) + CNTW'(1);
    assign b_next    = CNTW'(r_b) + CNTW'(1);
    assign a_plus2   = CNTW'(r_a) + CNTW'(2);

    always_comb begin
        n_state  = r_state;
        n_loaded = r_loaded;
        n_ovf    = r_ovf;
        n_valid  = r_valid;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_run    = r_run;
        n_best   = r_best;
        n_bf     = r_bf;
        n_bs     = r_bs;
        mem_we   = 1'b0;
        rd_addr  = r_k;
        ctl      = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_loaded < CNTW'(MAX_POINTS)) begin
                        mem_we   = 1'b1;
                        n_loaded = cnt_after;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_point) begin
                        n_valid = (n_loaded >= CNTW'(2));
                        n_best  = '0;
                        n_bf    = '0;
                        n_bs    = '0;
                        n_a     = '0;
                        n_b     = IDXW'(1);
                        n_state = n_valid ? S_RDA : S_OUT;
                    end
                end
            end
            S_RDA: begin
                rd_addr = r_a;
                n_run   = '0;
                n_state = S_RDB;
            end
            S_RDB: begin
                rd_addr    = r_b;
                ctl.load_a = 1'b1;
                n_state    = S_AB;
            end
            S_AB: begin
                rd_addr     = '0;
                ctl.load_ab = 1'b1;
                n_state     = S_PRIME;
            end
            S_PRIME: begin
                ctl.load_k = 1'b1;
                n_k        = '0;
                n_state    = S_PH0;
            end
            S_PH0: begin
                // fetch the next point while the first product forms
                rd_addr       = r_k + IDXW'(1);
                ctl.mul_first = 1'b1;
                n_state       = S_PH1;
            end
            S_PH1: begin
                ctl.load_k = 1'b1;
                n_run      = r_run + CNTW'(on_line);
                if (k_next == r_loaded) begin
                    n_state = S_PEND;
                end else begin
                    n_k     = r_k + IDXW'(1);
                    n_state = S_PH0;
                end
            end
            S_PEND: begin
                // strictly larger only: ties keep the earlier pair
                if (r_run > r_best) begin
                    n_best = r_run;
                    n_bf   = r_a;
                    n_bs   = r_b;
                end
                if (b_next < r_loaded) begin
                    n_b     = IDXW'(b_next);
                    n_state = S_RDA;
                end else if (a_plus2 < r_loaded) begin
                    n_a     = r_a + IDXW'(1);
                    n_b     = IDXW'(a_plus2);
                    n_state = S_RDA;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_loaded = '0;
                n_ovf    = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loaded <= '0;
            r_ovf    <= 1'b0;
            r_valid  <= 1'b0;
            r_a      <= '0;
            r_b      <= '0;
            r_k      <= '0;
            r_run    <= '0;
            r_best   <= '0;
            r_bf     <= '0;
            r_bs     <= '0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_ovf    <= n_ovf;
            r_valid  <= n_valid;
            r_a      <= n_a;
            r_b      <= n_b;
            r_k      <= n_k;
            r_run    <= n_run;
            r_best   <= n_best;
            r_bf     <= n_bf;
            r_bs     <= n_bs;
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_result_strobe  = (r_state == S_OUT);
    assign o_best_count     = r_best;
    assign o_first_index    = r_bf;
    assign o_second_index   = r_bs;
    assign o_line_valid     = r_valid;
    assign o_points_dropped = r_ovf;

endmodule

>>> rtl/core/mcp_checker.sv
// ============================================================================
// mcp_checker
// Port-level checks on the collinear point search, bound to the top level.
// ============================================================================
module mcp_checker #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_last_point,
    input logic                            o_result_strobe,
    input logic [$clog2(MAX_POINTS+1)-1:0] o_best_count,
    input logic [$clog2(MAX_POINTS)-1:0]   o_first_index,
    input logic [$clog2(MAX_POINTS)-1:0]   o_second_index,
    input logic                            o_line_valid
);

    // a closing transaction always makes the block busy
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_point |=> busy)
        else $error("closing point did not start the search");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe && !busy)
        else $error("result strobe longer than one cycle");

    // the defining pair always lies on its own line
    a_count_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_line_valid |-> o_best_count >= 2)
        else $error("valid line with fewer than two points");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_line_valid |-> o_first_index < o_second_index)
        else $error("winning pair out of order");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_line_valid |->
            o_best_count == '0 && o_first_index == '0 && o_second_index == '0)
        else $error("invalid result carries a line");

endmodule

bind max_collinear_points_unit mcp_checker #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
) u_mcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_last_point    (i_last_point),
    .o_result_strobe (o_result_strobe),
    .o_best_count    (o_best_count),
    .o_first_index   (o_first_index),
    .o_second_index  (o_second_index),
    .o_line_valid    (o_line_valid)
);

>>> dv/max_collinear_points_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// max_collinear_points_unit_test
// Loads point sets into the collinear point search and checks each reported
// line (count, defining pair, valid and dropped flags) against a predictor
// kept in the bench. Directed sets cover the corner cases; random sets plant
// a line among noise or use dense small values, with random pauses on the sending side.
// ============================================================================
module max_collinear_points_unit_test;

    localparam int MAX_PTS = 64;
    localparam int COORD_W = 16;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        logic [6:0] count;
        logic [5:0] first_idx;
        logic [5:0] second_idx;
        logic       valid;
        logic       dropped;
    } line_answer_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [COORD_W-1:0] i_point_x;
    logic [COORD_W-1:0] i_point_y;
    logic               i_last_point;
    logic               o_result_strobe;
    logic [6:0]         o_best_count;
    logic [5:0]         o_first_index;
    logic [5:0]         o_second_index;
    logic               o_line_valid;
    logic               o_points_dropped;

    // points of the set being loaded, as the block should hold them
    coord_t       held_x[$];
    coord_t       held_y[$];
    bit           held_overflow;
    line_answer_t expected_lines[$];

    // set being prepared for sending
    coord_t staged_x[$];
    coord_t staged_y[$];

    bit sender_eager;
    int points_sent;
    int sets_sent;
    int overflow_sets;
    int results_seen;
    int mismatches;
    int max_count_seen;

    max_collinear_points_unit #(
        .MAX_POINTS  (MAX_PTS),
        .COORD_WIDTH (COORD_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_last_point     (i_last_point),
        .o_result_strobe  (o_result_strobe),
        .o_best_count     (o_best_count),
        .o_first_index    (o_first_index),
        .o_second_index   (o_second_index),
        .o_line_valid     (o_line_valid),
        .o_points_dropped (o_points_dropped)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Line search predictor
    // ------------------------------------------------------------------------
    function automatic bit shares_line(int a, int b, int k);
        longint dxab;
        longint dyab;
        longint dxak;
        longint dyak;
        dxab = longint'(held_x[b]) - longint'(held_x[a]);
        dyab = longint'(held_y[b]) - longint'(held_y[a]);
        // coincident pair stands for the horizontal line through it
        if (dxab == 0 && dyab == 0)
            return held_y[k] == held_y[a];
        dxak = longint'(held_x[k]) - longint'(held_x[a]);
        dyak = longint'(held_y[k]) - longint'(held_y[a]);
        return dxab * dyak == dyab * dxak;
    endfunction

    function automatic line_answer_t search_best_line();
        line_answer_t ans;
        int n;
        int cnt;
        ans = '{default: 0};
        n = held_x.size();
        ans.valid = (n >= 2);
        ans.dropped = held_overflow;
        if (n >= 2) begin
            for (int i = 0; i + 1 < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    cnt = 0;
                    for (int k = 0; k < n; k++) begin
                        if (shares_line(i, j, k))
                            cnt++;
                    end
                    // ties keep the earlier pair
                    if (cnt > ans.count) begin
                        ans.count = 7'(cnt);
                        ans.first_idx = 6'(i);
                        ans.second_idx = 6'(j);
                    end
                end
            end
        end
        return ans;
    endfunction

    function automatic void record_point(coord_t x, coord_t y, bit last);
        line_answer_t ans;
        points_sent++;
        if (held_x.size() < MAX_PTS) begin
            held_x = {held_x, x};
            held_y = {held_y, y};
        end else begin
            held_overflow = 1'b1;
        end
        if (last) begin
            ans = search_best_line();
            expected_lines = {expected_lines, ans};
            if (ans.dropped)
                overflow_sets++;
            if (int'(ans.count) > max_count_seen)
                max_count_seen = int'(ans.count);
            sets_sent++;
            held_x.delete();
            held_y.delete();
            held_overflow = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        line_answer_t want;
        if (i_rst_n && o_result_strobe) begin
            results_seen++;
            if (expected_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: count %0d pair %0d,%0d",
                             $realtime, o_best_count, o_first_index, o_second_index);
            end else begin
                want = expected_lines.pop_front();
                if (o_best_count !== want.count || o_first_index !== want.first_idx ||
                    o_second_index !== want.second_idx || o_line_valid !== want.valid ||
                    o_points_dropped !== want.dropped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected count %0d pair %0d,%0d valid %0b dropped %0b",
                                 $realtime, want.count, want.first_idx, want.second_idx,
                                 want.valid, want.dropped);
                        $display("%0t: actual   count %0d pair %0d,%0d valid %0b dropped %0b",
                                 $realtime, o_best_count, o_first_index, o_second_index,
                                 o_line_valid, o_points_dropped);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------------
    task automatic send_point(coord_t x, coord_t y, bit last);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (busy);
        record_point(x, y, last);
    endtask

    task automatic send_staged_set();
        for (int i = 0; i < staged_x.size(); i++)
            send_point(staged_x[i], staged_y[i], i == staged_x.size() - 1);
        staged_x.delete();
        staged_y.delete();
    endtask

    // hold off the sender until every line found so far has been reported
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void stage(int x, int y);
        staged_x = {staged_x, coord_t'(x)};
        staged_y = {staged_y, coord_t'(y)};
    endfunction

    function automatic coord_t any_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_W-1:0];
    endfunction

    // a set with one planted line (or dense small values) among noise points
    function automatic void make_random_set(int size);
        int mode;
        int bx;
        int by;
        int dx;
        int dy;
        int on_count;
        int j;
        coord_t tx;
        coord_t ty;
        mode = $urandom_range(0, 3);
        bx = $urandom_range(0, 40000) - 20000;
        by = $urandom_range(0, 40000) - 20000;
        dx = $urandom_range(0, 128) - 64;
        dy = $urandom_range(0, 128) - 64;
        case ($urandom_range(0, 5))
            0: dx = 0;
            1: dy = 0;
            2: begin
                dx = 0;
                dy = 0;
            end
            default: ;
        endcase
        on_count = (size >= 2) ? $urandom_range(2, size) : 0;
        for (int i = 0; i < size; i++) begin
            if (mode == 0) begin
                stage($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
            end else if (i < on_count) begin
                j = $urandom_range(0, 200) - 100;
                stage(bx + j * dx, by + j * dy);
            end else begin
                staged_x = {staged_x, any_coord()};
                staged_y = {staged_y, any_coord()};
            end
        end
        for (int i = size - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tx = staged_x[i];
            ty = staged_y[i];
            staged_x[i] = staged_x[j];
            staged_y[i] = staged_y[j];
            staged_x[j] = tx;
            staged_y[j] = ty;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_single_point();
        stage(-32768, 32767);
        send_staged_set();
    endtask

    task automatic test_two_points();
        stage(32767, -32768);
        stage(-32768, 32767);
        send_staged_set();
    endtask

    task automatic test_identical_pair();
        stage(5, 7);
        stage(5, 7);
        stage(100, 7);
        stage(3, 9);
        stage(5, 7);
        send_staged_set();
    endtask

    task automatic test_equal_counts();
        stage(10, 5);
        stage(0, 0);
        stage(11, 5);
        stage(1, 1);
        stage(12, 5);
        stage(2, 2);
        send_staged_set();
    endtask

    task automatic test_extreme_coords();
        stage(-32768, -32768);
        stage(32767, 32767);
        stage(0, -1);
        stage(-1, 0);
        stage(32767, -32768);
        send_staged_set();
    endtask

    // full set plus two extra; the last-marked point itself is discarded
    task automatic test_capacity_overflow();
        for (int i = 0; i < MAX_PTS + 2; i++) begin
            if (i == 40 || i == 47 || i == 55 || i == 62) begin
                stage(1000 + 37 * (i - 40), -2000 - 11 * (i - 40));
            end else begin
                staged_x = {staged_x, any_coord()};
                staged_y = {staged_y, any_coord()};
            end
        end
        send_staged_set();
    endtask

    task automatic test_random_sets();
        int sent_here;
        int size;
        int r;
        sent_here = 0;
        while (sent_here < 200) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                size = 1;
            else if (r < 16)
                size = $urandom_range(2, 8);
            else
                size = $urandom_range(9, 12);
            make_random_set(size);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            sender_eager = ($urandom_range(0, 3) == 0);
            send_staged_set();
            sent_here += size;
        end
        sender_eager = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_last_point  = 1'b0;
        held_overflow = 1'b0;
        sender_eager  = 1'b0;
        points_sent    = 0;
        sets_sent      = 0;
        overflow_sets  = 0;
        results_seen   = 0;
        mismatches     = 0;
        max_count_seen = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_point();
        test_two_points();
        wait_drained();
        test_identical_pair();
        sender_eager = 1'b1;
        test_equal_counts();
        sender_eager = 1'b0;
        test_extreme_coords();
        wait_drained();
        test_capacity_overflow();
        test_random_sets();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_lines.size() != 0)
            mismatches++;

        $display("Covered %0d point sets from %0d points, %0d of them over capacity;",
                 sets_sent, points_sent, overflow_sets);
        $display("%0d results checked, longest line held %0d points, %0d mismatches.",
                 results_seen, max_count_seen, mismatches);
        if (mismatches == 0)
            $display("max_collinear_points_unit test passed");
        else
            $display("max_collinear_points_unit test failed");
        $finish;
    end

    // allow several times the whole run, full set search included
    initial begin
        #24_000_000;
        $display("Timed out waiting for the search to finish");
        $display("max_collinear_points_unit test failed");
        $finish;
    end

endmodule
